@@ rtl/ged_pkg.sv @@
// Package for the gradient edge detector.
// Holds beat types, the stage-one op struct and register index codes; no dependencies.
package ged_pkg;

  localparam int PixW   = 8;
  localparam int WidthW = 11;
  localparam int HeightW = 16;
  localparam int CfgW   = 16;

  localparam logic [PixW-1:0]    SatLimit     = 8'd255;
  localparam logic [WidthW-1:0]  WidthReset   = 11'd10;
  localparam logic [HeightW-1:0] HeightReset  = 16'd10;
  localparam logic [WidthW-1:0]  MinWidth     = 11'd3;
  localparam logic [HeightW-1:0] MinHeight    = 16'd3;

  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  localparam logic ModePixel = 1'b0;
  localparam logic ModeDrain = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [PixW-1:0] pixel;
  } ged_in_t;

  typedef struct packed {
    logic [PixW-1:0] edge_res;
    logic            end_of_row;
    logic            end_of_frame;
  } ged_out_t;

  // one item held between the counter stage and the gradient stage
  typedef struct packed {
    logic            drain;
    logic            first_col;
    logic            last_col;
    logic            emit;
    logic            interior;
    logic            frame_end;
    logic [PixW-1:0] pixel;
  } ged_op_t;

endpackage

@@ rtl/ged_row_mem.sv @@
// Row store: one word per column holding {older row pixel, newer row pixel}.
// One write port, two registered read ports. Uses ged_pkg for the pixel width.
module ged_row_mem #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AddrW-1:0]            rd_addr_a_i,
  input  logic [AddrW-1:0]            rd_addr_b_i,
  output logic [2*ged_pkg::PixW-1:0]  rd_data_a_o,
  output logic [2*ged_pkg::PixW-1:0]  rd_data_b_o,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [2*ged_pkg::PixW-1:0]  wr_data_i
);
  import ged_pkg::*;

  logic [2*PixW-1:0] mem_q [Depth];
  logic [2*PixW-1:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

@@ rtl/ged_front.sv @@
// Input stage: config registers, position and drain counters, memory read issue,
// and the stage-one op register. Uses ged_pkg.
module ged_front #(
  parameter int MaxWidth = 1024,
  parameter int AddrW    = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [ged_pkg::CfgW-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ged_pkg::ged_in_t        in_data_i,
  input  logic                    adv_i,
  output logic                    s1_valid_o,
  output ged_pkg::ged_op_t        s1_op_o,
  output logic [AddrW-1:0]        s1_addr_o,
  output logic                    rd_en_o,
  output logic [AddrW-1:0]        rd_addr_a_o,
  output logic [AddrW-1:0]        rd_addr_b_o
);
  import ged_pkg::*;

  localparam int UsedW = $clog2(MaxWidth + 1);
  localparam int CmpW  = (UsedW > WidthW) ? UsedW : WidthW;
  localparam logic [CmpW-1:0] MaxW = CmpW'(MaxWidth);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [AddrW-1:0]   col_q, dcnt_q;
  logic [HeightW-1:0] row_q;
  logic               dpend_q;
  logic               s1_valid_q;
  ged_op_t            s1_op_q;
  logic [AddrW-1:0]   s1_addr_q;

  logic [CmpW-1:0]    used_w, col_ext, c_ext;
  logic [HeightW-1:0] used_h, r;
  logic [AddrW-1:0]   c;
  logic               last_col, last_row, dlast, accept, take, is_drain;
  ged_op_t            op;

  always_comb begin
    used_w = CmpW'(width_q);
    if (width_q < MinWidth) used_w = CmpW'(MinWidth);
    if (used_w > MaxW) used_w = MaxW;
    col_ext = CmpW'(col_q);
    c_ext = (col_ext >= used_w) ? used_w - 1'b1 : col_ext;
    c = c_ext[AddrW-1:0];
    last_col = (c_ext + 1'b1) >= used_w;
    used_h = (height_q < MinHeight) ? MinHeight : height_q;
    r = (row_q >= used_h) ? used_h - 1'b1 : row_q;
    last_row = ({1'b0, r} + 1'b1) >= {1'b0, used_h};
    dlast = (CmpW'(dcnt_q) + 1'b1) >= used_w;
  end

  assign is_drain   = (in_data_i.mode == ModeDrain);
  assign in_ready_o = !s1_valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = accept && (!is_drain || dpend_q);

  always_comb begin
    op.drain     = is_drain;
    op.pixel     = in_data_i.pixel;
    op.first_col = (c == '0);
    op.last_col  = is_drain ? dlast : last_col;
    op.emit      = is_drain || (r != '0);
    op.interior  = (r != '0) && (r != HeightW'(1)) && (c != '0) && !last_col;
    op.frame_end = is_drain && dlast;
  end

  assign rd_en_o     = accept && !is_drain;
  assign rd_addr_a_o = c;
  assign rd_addr_b_o = last_col ? c : c + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegImageWidth:  width_q  <= cfg_data_i[WidthW-1:0];
        RegImageHeight: height_q <= cfg_data_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      dcnt_q  <= '0;
      dpend_q <= 1'b0;
    end else if (accept && !is_drain) begin
      if (last_col) begin
        col_q <= '0;
        if (last_row) begin
          row_q   <= '0;
          dpend_q <= 1'b1;
          dcnt_q  <= '0;
        end else begin
          row_q <= r + 1'b1;
        end
      end else begin
        col_q <= c + 1'b1;
      end
    end else if (accept && dpend_q) begin
      if (dlast) begin
        dpend_q <= 1'b0;
        dcnt_q  <= '0;
      end else begin
        dcnt_q <= dcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_op_q   <= op;
      s1_addr_q <= c;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_op_o    = s1_op_q;
  assign s1_addr_o  = s1_addr_q;

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(col_q) < MaxW) else $error("column counter out of range");
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv_i) |=> (s1_valid_q && $stable(s1_op_q) && $stable(s1_addr_q)))
    else $error("stalled stage-one beat changed");
  a_drain_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && is_drain) |-> !rd_en_o) else $error("drain beat read the row store");

endmodule

@@ rtl/ged_back.sv @@
// Gradient stage: middle-row window, edge sum with saturation, row store
// write-back and the output register. Uses ged_pkg.
module ged_back #(
  parameter int AddrW = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s1_valid_i,
  input  ged_pkg::ged_op_t           s1_op_i,
  input  logic [AddrW-1:0]           s1_addr_i,
  output logic                       adv_o,
  input  logic [2*ged_pkg::PixW-1:0] rd_data_a_i,
  input  logic [2*ged_pkg::PixW-1:0] rd_data_b_i,
  output logic                       wr_en_o,
  output logic [AddrW-1:0]           wr_addr_o,
  output logic [2*ged_pkg::PixW-1:0] wr_data_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ged_pkg::ged_out_t          out_data_o
);
  import ged_pkg::*;

  logic [PixW-1:0] win_q [3];
  logic [PixW-1:0] win_d [3];
  logic [PixW-1:0] older_a, newer_a, newer_b, dx, dy;
  logic [PixW:0]   sum;
  logic            fire, out_valid_q;
  ged_out_t        res, out_data_q;

  assign older_a = rd_data_a_i[2*PixW-1:PixW];
  assign newer_a = rd_data_a_i[PixW-1:0];
  assign newer_b = rd_data_b_i[PixW-1:0];

  assign adv_o = !out_valid_q || out_ready_i;
  assign fire  = s1_valid_i && adv_o;

  always_comb begin
    if (s1_op_i.first_col) begin
      win_d[0] = '0;
      win_d[1] = newer_a;
      win_d[2] = newer_b;
    end else begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = s1_op_i.last_col ? '0 : newer_b;
    end
    dx  = (win_d[2] >= win_d[0]) ? win_d[2] - win_d[0] : win_d[0] - win_d[2];
    dy  = (older_a >= s1_op_i.pixel) ? older_a - s1_op_i.pixel : s1_op_i.pixel - older_a;
    sum = {1'b0, dx} + {1'b0, dy};
    res.edge_res = '0;
    if (!s1_op_i.drain && s1_op_i.interior) begin
      res.edge_res = sum[PixW] ? SatLimit : sum[PixW-1:0];
    end
    res.end_of_row   = s1_op_i.last_col;
    res.end_of_frame = s1_op_i.frame_end;
  end

  assign wr_en_o   = fire && !s1_op_i.drain;
  assign wr_addr_o = s1_addr_i;
  assign wr_data_o = {newer_a, s1_op_i.pixel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (fire && !s1_op_i.drain) begin
      win_q[0] <= win_d[0];
      win_q[1] <= win_d[1];
      win_q[2] <= win_d[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= s1_valid_i && s1_op_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_frame_end_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.end_of_frame) |-> out_data_q.end_of_row)
    else $error("frame end without row end");
  a_row_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.end_of_row) |-> (out_data_q.edge_res == '0))
    else $error("nonzero edge on border column");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("output beat lost under stall");

endmodule

@@ rtl/gradient_edge_detector_top.sv @@
// Top level of the gradient edge detector.
// Instantiates ged_front, ged_row_mem and ged_back; uses ged_pkg.
//
// Input beats carry a mode bit and an 8-bit pixel in raster order; pixel beats
// of row r give the edge results of row r-1, so row 0 gives nothing. After
// the last row arrives, drain beats (mode 1) give the final all-zero row,
// one result per beat, and the last one carries end_of_frame. Drain beats
// with nothing pending are taken and dropped.
// Throughput: one beat per cycle unless the receiver stalls; the row store has
// separate read and write ports, so column c+1 is read as column c is written.
// Reset clears counters, the window and the handshake state and sets width
// and height to 10; the row store is not cleared and is filled by row 0.
// When the receiver stalls, the output register holds and one more beat can
// sit in the gradient stage; then in_ready_o drops until the output moves.
// Width and height are to be written through cfg_we_i only while the block is
// idle; the block itself does not enforce this, so the user must keep to it.
module gradient_edge_detector_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [ged_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  ged_pkg::ged_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ged_pkg::ged_out_t        out_data_o
);
  import ged_pkg::*;

  localparam int AddrW = $clog2(MAX_WIDTH);

  logic              adv, s1_valid, rd_en, wr_en;
  ged_op_t           s1_op;
  logic [AddrW-1:0]  s1_addr, rd_addr_a, rd_addr_b, wr_addr;
  logic [2*PixW-1:0] rd_data_a, rd_data_b, wr_data;

  ged_front #(
    .MaxWidth (MAX_WIDTH),
    .AddrW    (AddrW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .adv_i       (adv),
    .s1_valid_o  (s1_valid),
    .s1_op_o     (s1_op),
    .s1_addr_o   (s1_addr),
    .rd_en_o     (rd_en),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b)
  );

  ged_row_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data)
  );

  ged_back #(
    .AddrW (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_op_i     (s1_op),
    .s1_addr_i   (s1_addr),
    .adv_o       (adv),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for gradient_edge_detector_top: random raster frames,
// drain beats and register changes, checked beat by beat against an in-line predictor.
// Depends on rtl/ged_pkg.sv and the gradient_edge_detector_top RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ged_pkg::*;

  localparam int MaxWidth   = 1024;
  localparam int ItemTarget = 1650;
  localparam int SettleCyc  = 4;
  localparam int HoldCyc    = 200;

  logic            clk_i;
  logic            rst_ni   = 1'b0;
  logic            cfg_we   = 1'b0;
  logic            cfg_idx  = RegImageWidth;
  logic [CfgW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  ged_in_t         in_data  = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  ged_out_t        out_data;

  // predictor state
  bit [PixW-1:0]    row_above [MaxWidth];
  bit [PixW-1:0]    row_mid [MaxWidth];
  bit [PixW-1:0]    win [3];
  int unsigned      col_pos, row_pos, drain_pos;
  bit               drain_due;
  logic [WidthW-1:0]  width_reg  = WidthReset;
  logic [HeightW-1:0] height_reg = HeightReset;

  ged_in_t     beat_q[$];
  ged_out_t    edge_exp_q[$];

  int unsigned fail_cnt, beats_sent, results_seen, sat_seen, frames_done, mid_changes;
  bit          idle_on = 1'b1;
  bit          hold_arm = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left, stall_left, gap_left;

  gradient_edge_detector_top #(
    .MAX_WIDTH(MaxWidth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned used_w();
    int unsigned w;
    w = 32'(width_reg);
    if (w < MinWidth) w = 32'(MinWidth);
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int unsigned used_h();
    int unsigned h;
    h = 32'(height_reg);
    if (h < MinHeight) h = 32'(MinHeight);
    return h;
  endfunction

  function automatic int unsigned pix_dist(int unsigned a, int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic int unsigned pixels_left();
    int unsigned w, h, c, r;
    w = used_w();
    h = used_h();
    c = (col_pos < w) ? col_pos : w - 1;
    r = (row_pos < h) ? row_pos : h - 1;
    return (w - c) + (h - 1 - r) * w;
  endfunction

  task automatic predict_beat(input ged_in_t b);
    int unsigned w, h, c, r, mag;
    bit          last_col;
    ged_out_t    res;
    w = used_w();
    h = used_h();
    if (b.mode == ModeDrain) begin
      if (drain_due) begin
        last_col = (drain_pos + 1 >= w);
        res.edge_res     = '0;
        res.end_of_row   = last_col;
        res.end_of_frame = last_col;
        edge_exp_q.push_back(res);
        if (last_col) begin
          drain_due = 1'b0;
          drain_pos = 0;
        end else begin
          drain_pos++;
        end
      end
    end else begin
      c = (col_pos < w) ? col_pos : w - 1;
      r = (row_pos < h) ? row_pos : h - 1;
      last_col = (c + 1 >= w);
      if (c == 0) begin
        win[0] = '0;
        win[1] = row_mid[0];
        win[2] = row_mid[1];
      end else begin
        win[0] = win[1];
        win[1] = win[2];
        win[2] = last_col ? '0 : row_mid[c + 1];
      end
      if (r >= 1) begin
        mag = 0;
        if (r != 1 && c != 0 && !last_col) begin
          mag = pix_dist(32'(win[2]), 32'(win[0])) +
                pix_dist(32'(row_above[c]), 32'(b.pixel));
          if (mag > SatLimit) mag = 32'(SatLimit);
        end
        res.edge_res     = mag[PixW-1:0];
        res.end_of_row   = last_col;
        res.end_of_frame = 1'b0;
        edge_exp_q.push_back(res);
      end
      row_above[c] = row_mid[c];
      row_mid[c]   = b.pixel;
      if (last_col) begin
        col_pos = 0;
        if (r + 1 >= h) begin
          row_pos   = 0;
          drain_due = 1'b1;
          drain_pos = 0;
        end else begin
          row_pos = r + 1;
        end
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  task automatic flag_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_cnt++;
      if (fail_cnt <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap_left <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (beat_q.size() != 0) begin
        in_data  <= beat_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_arm && !hold_done && out_valid) begin
      hold_left <= HoldCyc;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // predictor and checker
  always @(posedge clk_i) begin
    ged_out_t want;
    if (rst_ni) begin
      if (cfg_we) begin
        if (cfg_idx == RegImageWidth) width_reg = cfg_data[WidthW-1:0];
        else height_reg = cfg_data[HeightW-1:0];
      end
      if (in_valid && in_ready) predict_beat(in_data);
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.edge_res == SatLimit) sat_seen++;
        if (out_data.end_of_frame) frames_done++;
        if (edge_exp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 40)
            $display("%0t: unexpected beat, expected none, got %p", $time, out_data);
        end else begin
          want = edge_exp_q.pop_front();
          flag_field("edge_res", 32'(want.edge_res), 32'(out_data.edge_res));
          flag_field("end_of_row", 32'(want.end_of_row), 32'(out_data.end_of_row));
          flag_field("end_of_frame", 32'(want.end_of_frame), 32'(out_data.end_of_frame));
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (beat_q.size() != 0 || in_valid || edge_exp_q.size() != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic push_pixel(input logic [PixW-1:0] p);
    ged_in_t b;
    b.mode  = ModePixel;
    b.pixel = p;
    beat_q.push_back(b);
    beats_sent++;
  endtask

  task automatic push_drain();
    ged_in_t b;
    b.mode  = ModeDrain;
    b.pixel = PixW'($urandom_range(0, 255));
    beat_q.push_back(b);
    beats_sent++;
  endtask

  function automatic logic [PixW-1:0] pick_pixel(input int unsigned style);
    case (style)
      0: return PixW'($urandom_range(0, 255));
      1: return ($urandom_range(0, 2) == 0) ? PixW'($urandom_range(0, 255)) :
                ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
      default: return PixW'($urandom_range(120, 135));
    endcase
  endfunction

  task automatic push_pixels(input int unsigned n, input int unsigned style);
    repeat (n) push_pixel(pick_pixel(style));
  endtask

  initial begin
    int unsigned w, h, n, cut, pick, style, frame_no, quota;
    bit          mid, wide;
    byte unsigned dir_px[18];
    dir_px = '{0, 0, 255, 0, 128, 255, 255, 255, 0,
               255, 255, 255, 255, 0, 0, 0, 255, 7};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 3x3 frames, saturation, ignored drains, restart of a pending drain
    write_reg(RegImageWidth, 16'hF803);
    write_reg(RegImageHeight, 16'd0);
    @(negedge clk_i);
    push_drain();
    for (int i = 0; i < 9; i++) push_pixel(dir_px[i]);
    push_drain();
    for (int i = 9; i < 18; i++) push_pixel(dir_px[i]);
    repeat (4) push_drain();
    settle();

    quota = ItemTarget + beats_sent;
    frame_no = 0;
    while (beats_sent < quota) begin
      mid = ($urandom_range(0, 4) == 0);
      wide = 1'b0;
      if (frame_no == 4) begin
        // full-width first row, then the width shrinks mid-frame
        write_reg(RegImageWidth, 16'h07FF);
        write_reg(RegImageHeight, 16'd3);
        mid = 1'b1;
        wide = 1'b1;
        hold_arm <= 1'b1;
      end else if (frame_no == 2) begin
        write_reg(RegImageWidth, CfgW'($urandom_range(3, 8)));
        write_reg(RegImageHeight, 16'hFFFF);
        mid = 1'b1;
      end else begin
        write_reg(RegImageWidth, {5'($urandom), 11'($urandom_range(0, 24))});
        write_reg(RegImageHeight, CfgW'($urandom_range(0, 8)));
      end
      idle_on <= (beats_sent + 300 < quota) && ($urandom_range(0, 3) != 0);
      @(negedge clk_i);
      style = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) push_drain();
      w = used_w();
      h = used_h();
      if (mid) begin
        if (wide) begin
          cut = w + $urandom_range(8, 24);
        end else begin
          cut = (w * h - 1 < 5 * w) ? w * h - 1 : 5 * w;
          cut = $urandom_range(1, cut);
        end
        push_pixels(cut, style);
        settle();
        if (h > 64 || $urandom_range(0, 1) == 0)
          write_reg(RegImageHeight, CfgW'($urandom_range(0, 8)));
        if (wide)
          write_reg(RegImageWidth, CfgW'($urandom_range(3, 8)));
        else if ($urandom_range(0, 1) == 0)
          write_reg(RegImageWidth, CfgW'($urandom_range(0, w)));
        mid_changes++;
        @(negedge clk_i);
      end
      push_pixels(pixels_left(), style);
      w = used_w();
      pick = $urandom_range(0, 5);
      n = (pick == 0) ? $urandom_range(0, w - 1) :
          (pick == 1) ? w + $urandom_range(1, 3) : w;
      repeat (n) push_drain();
      settle();
      frame_no++;
    end

    settle();
    $display("%0d input beats in %0d frames (%0d completed), %0d mid-frame register changes",
             beats_sent, frame_no, frames_done, mid_changes);
    $display("%0d edge results checked, %0d of them saturated", results_seen, sat_seen);
    if (fail_cnt == 0 && edge_exp_q.size() == 0) begin
      $display("gradient_edge_detector_top regression: pass");
    end else begin
      $display("gradient_edge_detector_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", edge_exp_q.size());
    $display("gradient_edge_detector_top regression: fail");
    $finish;
  end

endmodule
